// ----- rtl/rxs_pkg.sv -----
// rxs_pkg: shared types, constants and the key function for the record exchange sorter
// used by every rtl file of the block, depends on nothing
package rxs_pkg;

  localparam int KEY_W           = 10;
  localparam int TAG_W           = 16;
  localparam int MARK_W          = 7;
  localparam int MAX_RECORDS_DEF = 64;

  // input beat: one record
  typedef struct packed {
    logic [TAG_W-1:0]  roll_number;
    logic [MARK_W-1:0] mark_a;
    logic [MARK_W-1:0] mark_b;
    logic [MARK_W-1:0] mark_c;
    logic [MARK_W-1:0] mark_d;
    logic [MARK_W-1:0] mark_e;
    logic [MARK_W-1:0] mark_f;
    logic              last_record;
  } rxs_in_t;

  // output beat: one sorted record
  typedef struct packed {
    logic [TAG_W-1:0] out_roll_number;
    logic [KEY_W-1:0] out_total;
    logic             last_of_run;
  } rxs_out_t;

  // stored entry: key and tag side by side in one memory word
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rxs_entry_t;

  // sequencer to output register
  typedef struct packed {
    logic load;
    logic last;
  } rxs_emit_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_I,
    S_LD_I,
    S_CMP,
    S_WB,
    S_EMIT,
    S_EMIT_LD
  } rxs_state_t;

  // sum of six marks, at most 762, fits the key width
  function automatic logic [KEY_W-1:0] rxs_mark_sum(input rxs_in_t r);
    logic [KEY_W-1:0] s0;
    logic [KEY_W-1:0] s1;
    logic [KEY_W-1:0] s2;
    s0 = KEY_W'(r.mark_a) + KEY_W'(r.mark_b);
    s1 = KEY_W'(r.mark_c) + KEY_W'(r.mark_d);
    s2 = KEY_W'(r.mark_e) + KEY_W'(r.mark_f);
    return s0 + s1 + s2;
  endfunction

endpackage

// ----- rtl/record_exchange_sorter_unit.sv -----
// record_exchange_sorter_unit: top level, entry store, sequencer and output register
// depends on rxs_pkg, rxs_mem and rxs_seq
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_stall   | rxs_in_t  (tag, six marks, last_record)
//   out_    | out | out_valid / out_stall | rxs_out_t (tag, total, last_of_run)
//
// an accepted beat is stored while there is room; in_stall is low only while loading
// on last_record the sort runs passes of pivot read, pivot load, compares, write-back;
//   one compare per cycle, limited by the single read port of the entry store
// emit then reads each result from the store and loads it into the output register
// out_stall holds the output register and pauses emit; no clearing pass after reset
module record_exchange_sorter_unit
  import rxs_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rxs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rxs_out_t out_data
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  rxs_entry_t    mem_wdata;
  logic [AW-1:0] mem_raddr;
  rxs_entry_t    mem_rdata;
  rxs_emit_t     emit;
  logic          out_free;

  logic          out_valid_r, out_valid_nxt;
  rxs_out_t      out_data_r, out_data_nxt;

  rxs_mem #(
    .DEPTH (MAX_RECORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rxs_seq #(
    .MAX_RECORDS (MAX_RECORDS),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_free  (out_free),
    .emit      (emit),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register is free when empty or its beat leaves this cycle
  assign out_free = !out_valid_r || !out_stall;

  // output register next value
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_roll_number: mem_rdata.tag,
                        out_total:       mem_rdata.key,
                        last_of_run:     emit.last};
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/rxs_mem.sv -----
// rxs_mem: entry store, one write port and one read port with registered read data
// depends on rxs_pkg for the entry type
module rxs_mem
  import rxs_pkg::*;
#(
  parameter int DEPTH = MAX_RECORDS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rxs_entry_t      wdata,
  input  logic [AW-1:0]   raddr,
  output rxs_entry_t      rdata
);

  rxs_entry_t mem_r [DEPTH];
  rxs_entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rxs_seq.sv -----
// rxs_seq: load, exchange sort and emit sequencer working on the entry store
// depends on rxs_pkg; drives the ports of rxs_mem and the output register load
module rxs_seq
  import rxs_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int AW          = $clog2(MAX_RECORDS),
  parameter int CW          = $clog2(MAX_RECORDS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rxs_in_t       in_data,
  input  logic          out_free,
  output rxs_emit_t     emit,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output rxs_entry_t    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  rxs_entry_t    mem_rdata
);

  rxs_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  rxs_entry_t    piv_r, piv_nxt;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] load_n;
  logic [CW-1:0] ip1;
  logic [CW-1:0] ip2;
  logic [CW-1:0] jp1;
  logic          emit_last;

  assign in_stall  = (state_r != S_LOAD);
  assign accept    = in_valid && !in_stall;
  assign has_room  = (count_r < CW'(MAX_RECORDS));
  assign load_n    = has_room ? count_r + 1'b1 : count_r;
  assign ip1       = i_r + 1'b1;
  assign ip2       = i_r + 2'd2;
  assign jp1       = j_r + 1'b1;
  assign emit_last = (k_r == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept && in_data.last_record) begin
          state_nxt = (load_n >= CW'(2)) ? S_RD_I : S_EMIT;
        end
      end
      S_RD_I:    state_nxt = S_LD_I;
      S_LD_I:    state_nxt = S_CMP;
      S_CMP: begin
        if (jp1 >= count_r) begin
          state_nxt = S_WB;
        end
      end
      S_WB:      state_nxt = (ip2 < count_r) ? S_RD_I : S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_EMIT_LD;
        end
      end
      S_EMIT_LD: state_nxt = emit_last ? S_LOAD : S_EMIT;
      default:   state_nxt = S_LOAD;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    piv_nxt   = piv_r;
    mem_we    = 1'b0;
    mem_waddr = i_r[AW-1:0];
    mem_wdata = piv_r;
    mem_raddr = i_r[AW-1:0];
    emit      = '0;
    unique case (state_r)
      S_LOAD: begin
        // store tag and key at the fill position
        mem_waddr = count_r[AW-1:0];
        mem_wdata = '{key: rxs_mark_sum(in_data), tag: in_data.roll_number};
        if (accept && has_room) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        if (accept && in_data.last_record) begin
          i_nxt = '0;
          k_nxt = '0;
        end
      end
      S_RD_I: begin
        mem_raddr = i_r[AW-1:0];
      end
      S_LD_I: begin
        // entry i becomes the pivot, start reading j = i+1
        piv_nxt   = mem_rdata;
        j_nxt     = ip1;
        mem_raddr = ip1[AW-1:0];
      end
      S_CMP: begin
        // swap pivot with entry j when pivot key is larger
        mem_waddr = j_r[AW-1:0];
        if (piv_r.key > mem_rdata.key) begin
          mem_we  = 1'b1;
          piv_nxt = mem_rdata;
        end
        j_nxt     = jp1;
        mem_raddr = jp1[AW-1:0];
      end
      S_WB: begin
        // pivot holds the final value of entry i
        mem_we    = 1'b1;
        mem_waddr = i_r[AW-1:0];
        i_nxt     = ip1;
      end
      S_EMIT: begin
        mem_raddr = k_r[AW-1:0];
        if (out_free) begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_EMIT_LD: begin
        emit.load = 1'b1;
        emit.last = emit_last;
        if (emit_last) begin
          count_nxt = '0;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // loop indexes and pivot
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    piv_r <= piv_nxt;
  end

`ifndef SYNTHESIS
  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (j_r < count_r))
    else $error("compare index past stored count");

  a_pivot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_I) |-> (ip1 < count_r))
    else $error("pivot read with no entry after it");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_LD) |-> (k_r != '0 && k_r <= count_r))
    else $error("emit index out of range");

  a_last_leaves_load: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_record) |=> (state_r != S_LOAD))
    else $error("last record did not start sort or emit");
`endif

endmodule
